/* hdl/text_console_writer_top_assert.svh */
// Assertion macros for the text console writer checker.
// Used by: tcw_checker.sv.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("tcw: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("tcw: next-cycle check failed");

`endif

/* hdl/tcw_pkg.sv */
// Shared types, constants and helpers for the text console writer.
// No dependencies; used by every module of the block.
package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	// Field widths
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int ADDR_W = 11;
	localparam int CELL_W = 16;
	localparam int BIT_W  = $clog2(COL_W);

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_BLANK = 8'h20;

	// Register indexes
	localparam logic [1:0] CFG_TAB_WIDTH = 2'd0;
	localparam logic [1:0] CFG_TEXT_ATTR = 2'd1;
	localparam logic [1:0] CFG_FILL_ATTR = 2'd2;

	// Register reset values
	localparam logic [6:0] TAB_WIDTH_RST = 7'd8;
	localparam logic [7:0] TEXT_ATTR_RST = 8'd15;
	localparam logic [7:0] FILL_ATTR_RST = 8'h07;

	// Cell written by the clearing pass after reset
	localparam logic [CELL_W-1:0] RESET_CELL = {FILL_ATTR_RST, CH_BLANK};

	// Operations decoded by the front
	typedef enum logic [2:0] {
		OP_NOP,
		OP_NEWLINE,
		OP_BACKSPACE,
		OP_TAB,
		OP_PUT,
		OP_READ,
		OP_READ_NONE
	} op_t;

	// One queued item
	typedef struct packed {
		op_t               op;
		logic [7:0]        ch;
		logic [ADDR_W-1:0] idx;
	} item_t;

	// One result beat
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [ADDR_W-1:0] loc;
		logic [CELL_W-1:0] data;
		logic              scrolled;
	} res_t;

	// Linear cell address of a row and column
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
		return a;
	endfunction

endpackage

/* hdl/tcw_front.sv */
// Front end: takes input beats, decodes them into queue items.
// Depends on tcw_pkg.
module tcw_front (
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       mode,
	input  logic [7:0]                 char_code,
	input  logic [tcw_pkg::ADDR_W-1:0] read_index,
	input  logic                       q_full,
	input  logic                       clear_busy,
	output logic                       q_push,
	output tcw_pkg::item_t             q_item
);

	// Hold off while the queue is full or the store is being cleared
	assign in_stall = q_full | clear_busy;
	assign q_push   = in_valid & ~in_stall;

	// Decode the beat
	always_comb begin
		q_item.ch  = char_code;
		q_item.idx = read_index;
		if (mode) begin
			if (read_index < tcw_pkg::ADDR_W'(tcw_pkg::CELLS)) begin
				q_item.op = tcw_pkg::OP_READ;
			end else begin
				q_item.op = tcw_pkg::OP_READ_NONE;
			end
		end else begin
			case (char_code)
				tcw_pkg::CH_NUL: q_item.op = tcw_pkg::OP_NOP;
				tcw_pkg::CH_LF:  q_item.op = tcw_pkg::OP_NEWLINE;
				tcw_pkg::CH_BS:  q_item.op = tcw_pkg::OP_BACKSPACE;
				tcw_pkg::CH_TAB: q_item.op = tcw_pkg::OP_TAB;
				default:         q_item.op = tcw_pkg::OP_PUT;
			endcase
		end
	end

endmodule

/* hdl/tcw_fifo.sv */
// Small item queue between front and back.
// Depends on tcw_pkg.
module tcw_fifo #(
	parameter int DEPTH = tcw_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcw_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output tcw_pkg::item_t head,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tcw_pkg::item_t   store_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = store_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/tcw_back.sv */
// Back end: cursor, screen store, tab divider, scroll sweep, result register.
// Depends on tcw_pkg.
module tcw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [6:0]     tab_width,
	input  logic [7:0]     text_attr,
	input  logic [7:0]     fill_attr,
	input  logic           q_empty,
	input  tcw_pkg::item_t q_head,
	output logic           q_pop,
	output logic           clear_busy,
	output logic           out_valid,
	input  logic           out_stall,
	output tcw_pkg::res_t  out_res
);

	localparam int AW = tcw_pkg::ADDR_W;
	localparam int CW = tcw_pkg::COL_W;
	localparam int RW = tcw_pkg::ROW_W;
	localparam int DW = tcw_pkg::CELL_W;
	localparam int BW = tcw_pkg::BIT_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_RDATA,
		ST_TABDIV,
		ST_TABEND,
		ST_SCROLL,
		ST_FIN
	} state_t;

	state_t          state_q;
	tcw_pkg::item_t  item_q;
	logic [AW-1:0]   sc_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   rem_q;
	logic [BW-1:0]   bit_q;
	logic [DW-1:0]   cell_q;
	logic            scrolled_q;
	logic            mv_vld_s1;
	logic [AW-1:0]   mv_addr_s1;
	logic            mv_fill_s1;
	logic            out_valid_q;
	tcw_pkg::res_t   out_res_q;

	logic [DW-1:0]   mem [tcw_pkg::CELLS];
	logic [DW-1:0]   rd_data_q;
	logic [AW-1:0]   rd_addr;
	logic            mem_we;
	logic [AW-1:0]   mem_wa;
	logic [DW-1:0]   mem_wd;

	logic [CW-1:0]   tw_eff;
	logic [CW:0]     div_t;
	logic [CW-1:0]   div_rem;
	logic [CW:0]     tab_col;
	logic            out_free;
	logic            last_row;

	assign clear_busy = (state_q == ST_CLEAR);
	assign q_pop      = (state_q == ST_IDLE) && !q_empty;
	assign out_valid  = out_valid_q;
	assign out_res    = out_res_q;
	assign out_free   = !out_valid_q || !out_stall;
	assign last_row   = (row_q == RW'(tcw_pkg::ROWS - 1));

	// Tab divider: one remainder bit per cycle, then the next stop
	always_comb begin
		tw_eff  = (tab_width == '0) ? CW'(1) : tab_width;
		div_t   = {rem_q, col_q[bit_q]};
		div_rem = (div_t >= {1'b0, tw_eff}) ? CW'(div_t - {1'b0, tw_eff}) : CW'(div_t);
		tab_col = {1'b0, col_q} + {1'b0, tw_eff} - {1'b0, rem_q};
	end

	// Store write port and read address
	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = '0;
		mem_wd  = '0;
		rd_addr = (state_q == ST_EXEC) ? item_q.idx : AW'(sc_q + AW'(tcw_pkg::COLUMNS));
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = sc_q;
				mem_wd = tcw_pkg::RESET_CELL;
			end
			ST_EXEC: begin
				if (item_q.op == tcw_pkg::OP_PUT) begin
					mem_we = 1'b1;
					mem_wa = tcw_pkg::cell_addr(row_q, col_q);
					mem_wd = {text_attr, item_q.ch};
				end else if (item_q.op == tcw_pkg::OP_BACKSPACE && col_q != '0) begin
					mem_we = 1'b1;
					mem_wa = tcw_pkg::cell_addr(row_q, col_q - 1'b1);
					mem_wd = {text_attr, tcw_pkg::CH_BLANK};
				end
			end
			default: begin
			end
		endcase
		// Scroll sweep write stage
		if (mv_vld_s1) begin
			mem_we = 1'b1;
			mem_wa = mv_addr_s1;
			mem_wd = mv_fill_s1 ? {fill_attr, tcw_pkg::CH_BLANK} : rd_data_q;
		end
	end

	// Screen store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Sequencer, cursor and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			item_q      <= '0;
			sc_q        <= '0;
			col_q       <= '0;
			row_q       <= '0;
			rem_q       <= '0;
			bit_q       <= '0;
			cell_q      <= '0;
			scrolled_q  <= 1'b0;
			mv_vld_s1   <= 1'b0;
			mv_addr_s1  <= '0;
			mv_fill_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else begin
			mv_vld_s1 <= (state_q == ST_SCROLL);
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (sc_q == AW'(tcw_pkg::CELLS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						sc_q <= sc_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						item_q     <= q_head;
						cell_q     <= '0;
						scrolled_q <= 1'b0;
						state_q    <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
					case (item_q.op)
						tcw_pkg::OP_NEWLINE: begin
							col_q <= '0;
							if (last_row) begin
								scrolled_q <= 1'b1;
								sc_q       <= '0;
								state_q    <= ST_SCROLL;
							end else begin
								row_q <= row_q + 1'b1;
							end
						end
						tcw_pkg::OP_BACKSPACE: begin
							if (col_q != '0) begin
								col_q <= col_q - 1'b1;
							end else if (row_q != '0) begin
								row_q <= row_q - 1'b1;
								col_q <= CW'(tcw_pkg::COLUMNS - 1);
							end
						end
						tcw_pkg::OP_TAB: begin
							rem_q   <= '0;
							bit_q   <= BW'(CW - 1);
							state_q <= ST_TABDIV;
						end
						tcw_pkg::OP_PUT: begin
							if (col_q == CW'(tcw_pkg::COLUMNS - 1)) begin
								col_q <= '0;
								if (last_row) begin
									scrolled_q <= 1'b1;
									sc_q       <= '0;
									state_q    <= ST_SCROLL;
								end else begin
									row_q <= row_q + 1'b1;
								end
							end else begin
								col_q <= col_q + 1'b1;
							end
						end
						tcw_pkg::OP_READ: begin
							state_q <= ST_RDATA;
						end
						default: begin
						end
					endcase
				end
				ST_RDATA: begin
					cell_q  <= rd_data_q;
					state_q <= ST_FIN;
				end
				ST_TABDIV: begin
					rem_q <= div_rem;
					if (bit_q == '0) begin
						state_q <= ST_TABEND;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				ST_TABEND: begin
					state_q <= ST_FIN;
					if (tab_col >= (CW + 1)'(tcw_pkg::COLUMNS)) begin
						col_q <= '0;
						if (last_row) begin
							scrolled_q <= 1'b1;
							sc_q       <= '0;
							state_q    <= ST_SCROLL;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						col_q <= CW'(tab_col);
					end
				end
				ST_SCROLL: begin
					// read one row ahead, write in the next cycle; bottom row gets blanks
					mv_addr_s1 <= sc_q;
					mv_fill_s1 <= (sc_q >= AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS));
					if (sc_q == AW'(tcw_pkg::CELLS - 1)) begin
						state_q <= ST_FIN;
					end else begin
						sc_q <= sc_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q        <= 1'b1;
						out_res_q.col      <= col_q;
						out_res_q.row      <= row_q;
						out_res_q.loc      <= tcw_pkg::cell_addr(row_q, col_q);
						out_res_q.data     <= cell_q;
						out_res_q.scrolled <= scrolled_q;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/text_console_writer_top.sv */
// Text console writer top level: register port, front, queue, back.
// Depends on tcw_pkg, tcw_front, tcw_fifo, tcw_back.
//
//  channel  | handshake            | beat
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | mode, char_code, read_index
//  out      | out_valid / out_stall| cursor_column, cursor_row, cursor_location,
//           |                      | cell_data, scrolled
//  cfg      | cfg_we               | cfg_index, cfg_wdata
//
// Put, newline, backspace, NUL pass idle, execute and finish; in-range reads add a
// read-data state. A tab adds the one-bit-per-cycle remainder of column by tab
// width and a next-stop state. A scroll moves a cell per cycle via one write port.
// After reset a clearing pass writes all 2000 cells, one a cycle; in_stall is high
// for its length. in_stall also rises while the queue is full; a waiting result
// holds in the output register while the front keeps taking beats until it fills.
module text_console_writer_top #(
	parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       mode,
	input  logic [7:0]                 char_code,
	input  logic [tcw_pkg::ADDR_W-1:0] read_index,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tcw_pkg::COL_W-1:0]  cursor_column,
	output logic [tcw_pkg::ROW_W-1:0]  cursor_row,
	output logic [tcw_pkg::ADDR_W-1:0] cursor_location,
	output logic [tcw_pkg::CELL_W-1:0] cell_data,
	output logic                       scrolled,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [7:0]                 cfg_wdata
);

	logic [6:0]     tab_width_q;
	logic [7:0]     text_attr_q;
	logic [7:0]     fill_attr_q;
	logic           q_full;
	logic           q_empty;
	logic           q_push;
	logic           q_pop;
	logic           clear_busy;
	tcw_pkg::item_t push_item;
	tcw_pkg::item_t head_item;
	tcw_pkg::res_t  res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_width_q <= tcw_pkg::TAB_WIDTH_RST;
			text_attr_q <= tcw_pkg::TEXT_ATTR_RST;
			fill_attr_q <= tcw_pkg::FILL_ATTR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tcw_pkg::CFG_TAB_WIDTH: tab_width_q <= cfg_wdata[6:0];
				tcw_pkg::CFG_TEXT_ATTR: text_attr_q <= cfg_wdata;
				tcw_pkg::CFG_FILL_ATTR: fill_attr_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	tcw_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.char_code  (char_code),
		.read_index (read_index),
		.q_full     (q_full),
		.clear_busy (clear_busy),
		.q_push     (q_push),
		.q_item     (push_item)
	);

	tcw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.head      (head_item),
		.empty     (q_empty)
	);

	tcw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tab_width  (tab_width_q),
		.text_attr  (text_attr_q),
		.fill_attr  (fill_attr_q),
		.q_empty    (q_empty),
		.q_head     (head_item),
		.q_pop      (q_pop),
		.clear_busy (clear_busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_res    (res)
	);

	// Result beat onto the ports
	assign cursor_column   = res.col;
	assign cursor_row      = res.row;
	assign cursor_location = res.loc;
	assign cell_data       = res.data;
	assign scrolled        = res.scrolled;

endmodule

/* hdl/tcw_checker.sv */
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_top_assert.svh.
`include "text_console_writer_top_assert.svh"

module tcw_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [tcw_pkg::COL_W-1:0]  cursor_column,
	input logic [tcw_pkg::ROW_W-1:0]  cursor_row,
	input logic [tcw_pkg::ADDR_W-1:0] cursor_location,
	input logic [tcw_pkg::CELL_W-1:0] cell_data,
	input logic                       scrolled
);

	// A stalled result beat stays offered
	`TCW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// and keeps its payload
	`TCW_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(cursor_location) && $stable(cell_data))

	// Location agrees with row and column
	`TCW_ASSERT_NOW(a_loc, clk, arst_n, out_valid, cursor_location == (11'(cursor_row) * 11'(tcw_pkg::COLUMNS) + 11'(cursor_column)))

	// A scroll leaves the cursor on the last row
	`TCW_ASSERT_NOW(a_scroll_row, clk, arst_n, out_valid && scrolled, cursor_row == 5'(tcw_pkg::ROWS - 1))

	// Scrolled beats carry zero cell data: only reads return cell data, and reads never scroll
	`TCW_ASSERT_NOW(a_scroll_put, clk, arst_n, out_valid && scrolled, cell_data == 16'd0)

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (.*);

/* tb/sv/text_console_writer_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for text_console_writer_top: directed and random input beats.
// Depends on tcw_pkg and the RTL of the block; keeps its own shadow of screen and cursor.
module text_console_writer_top_tb;

	localparam logic       MODE_PUT       = 1'b0;
	localparam logic       MODE_READ      = 1'b1;
	localparam logic [1:0] CFG_SPARE      = 2'd3;
	localparam int         WATCHDOG_LIMIT = 20000;
	localparam int         DRAIN_CYCLES   = 50;
	localparam int         REPORT_MAX     = 10;
	localparam int         AW             = tcw_pkg::ADDR_W;
	localparam int         COLS           = tcw_pkg::COLUMNS;
	localparam int         NCELLS         = tcw_pkg::CELLS;

	// Result beat as the checker sees it
	typedef struct {
		logic [tcw_pkg::COL_W-1:0]  col;
		logic [tcw_pkg::ROW_W-1:0]  row;
		logic [AW-1:0]              loc;
		logic [tcw_pkg::CELL_W-1:0] data;
		logic                       scr;
	} console_beat_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic                       mode;
	logic [7:0]                 char_code;
	logic [AW-1:0]              read_index;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [tcw_pkg::COL_W-1:0]  cursor_column;
	logic [tcw_pkg::ROW_W-1:0]  cursor_row;
	logic [AW-1:0]              cursor_location;
	logic [tcw_pkg::CELL_W-1:0] cell_data;
	logic                       scrolled;
	logic                       cfg_we;
	logic [1:0]                 cfg_index;
	logic [7:0]                 cfg_wdata;

	// Shadow of the console state
	logic [tcw_pkg::CELL_W-1:0] shadow_cells [NCELLS];
	int                         shadow_col;
	int                         shadow_row;
	logic [6:0]                 shadow_tab;
	logic [7:0]                 shadow_text;
	logic [7:0]                 shadow_fill;

	console_beat_t     pending_beats [$];
	int                fault_count   = 0;
	int                idle_cycles   = 0;
	int                send_idle_pct = 0;
	int                recv_stall_pct = 0;

	text_console_writer_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.char_code      (char_code),
		.read_index     (read_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cursor_column  (cursor_column),
		.cursor_row     (cursor_row),
		.cursor_location(cursor_location),
		.cell_data      (cell_data),
		.scrolled       (scrolled),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Moves the shadow cursor wrap and scroll; returns the beat the block should give
	function automatic console_beat_t predict_console(input logic m, input logic [7:0] code,
		input logic [AW-1:0] idx);
		console_beat_t b;
		int            tw;
		b.data = '0;
		b.scr  = 1'b0;
		if (m == MODE_READ) begin
			if (idx < NCELLS)
				b.data = shadow_cells[idx];
		end else begin
			case (code)
				tcw_pkg::CH_NUL: ;
				tcw_pkg::CH_LF: begin
					shadow_col = 0;
					shadow_row++;
				end
				tcw_pkg::CH_BS: begin
					// at column 0 step up a row without blanking; at the origin stay put
					if (shadow_col == 0) begin
						if (shadow_row != 0) begin
							shadow_row--;
							shadow_col = COLS - 1;
						end
					end else begin
						shadow_col--;
						shadow_cells[shadow_row * COLS + shadow_col] =
							{shadow_text, tcw_pkg::CH_BLANK};
					end
				end
				tcw_pkg::CH_TAB: begin
					tw = (shadow_tab == 0) ? 1 : int'(shadow_tab);
					shadow_col += tw - shadow_col % tw;
					if (shadow_col >= COLS) begin
						shadow_col = 0;
						shadow_row++;
					end
				end
				default: begin
					shadow_cells[shadow_row * COLS + shadow_col] = {shadow_text, code};
					shadow_col++;
					if (shadow_col >= COLS) begin
						shadow_col = 0;
						shadow_row++;
					end
				end
			endcase
			// past the last row: shift up one row, blank the bottom one
			if (shadow_row >= tcw_pkg::ROWS) begin
				for (int k = 0; k < NCELLS - COLS; k++)
					shadow_cells[k] = shadow_cells[k + COLS];
				for (int k = NCELLS - COLS; k < NCELLS; k++)
					shadow_cells[k] = {shadow_fill, tcw_pkg::CH_BLANK};
				shadow_row = tcw_pkg::ROWS - 1;
				b.scr      = 1'b1;
			end
		end
		b.col = tcw_pkg::COL_W'(shadow_col);
		b.row = tcw_pkg::ROW_W'(shadow_row);
		b.loc = AW'(shadow_row * COLS + shadow_col);
		return b;
	endfunction

	// One input beat; called and left at a falling edge
	task automatic send_beat(input logic m, input logic [7:0] code, input logic [AW-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		char_code  <= code;
		read_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_beats.push_back(predict_console(m, code, idx));
		@(negedge clk);
	endtask

	task automatic put_char(input logic [7:0] code);
		send_beat(MODE_PUT, code, AW'($urandom_range(2047)));
	endtask

	task automatic read_cell(input logic [AW-1:0] idx);
		send_beat(MODE_READ, 8'($urandom_range(255)), idx);
	endtask

	// Let every outstanding result come back before touching the registers
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_beats.size() != 0);
	endtask

	// Write all registers, plus the unused index, on consecutive cycles
	task automatic program_console(input logic [7:0] tab, input logic [7:0] text,
		input logic [7:0] fill);
		cfg_we    <= 1'b1;
		cfg_index <= tcw_pkg::CFG_TAB_WIDTH;
		cfg_wdata <= tab;
		@(negedge clk);
		cfg_index <= tcw_pkg::CFG_TEXT_ATTR;
		cfg_wdata <= text;
		@(negedge clk);
		cfg_index <= tcw_pkg::CFG_FILL_ATTR;
		cfg_wdata <= fill;
		@(negedge clk);
		cfg_index <= CFG_SPARE;
		cfg_wdata <= 8'($urandom_range(255));
		@(negedge clk);
		cfg_we      <= 1'b0;
		shadow_tab  = tab[6:0];
		shadow_text = text;
		shadow_fill = fill;
	endtask

	// Reset contents, out-of-range reads and the cursor control codes at default settings
	task automatic test_cursor_controls();
		read_cell(AW'(0));
		read_cell(AW'(NCELLS - 1));
		read_cell(AW'(NCELLS));
		read_cell(AW'(2047));
		put_char(tcw_pkg::CH_BS);   // backspace at the origin
		put_char(tcw_pkg::CH_NUL);
		put_char(8'h41);
		put_char(8'hFF);
		put_char(8'h01);            // control code stored as a plain character
		put_char(tcw_pkg::CH_BS);   // blank with text attribute
		put_char(tcw_pkg::CH_TAB);
		put_char(8'h7E);
		put_char(tcw_pkg::CH_LF);
		put_char(tcw_pkg::CH_BS);   // column 0: back to the end of the row above
		put_char(8'h5A);            // last column, wraps
		read_cell(AW'(COLS - 1));
		read_cell(AW'(0));
		read_cell(AW'(2));
		drain_results();
	endtask

	// Tab width of zero and above the row length; fill change leaves stored cells alone
	task automatic test_tab_width_extremes();
		program_console(8'h00, 8'h00, 8'hFF);
		put_char(tcw_pkg::CH_TAB);
		put_char(tcw_pkg::CH_TAB);
		put_char(8'h80);
		read_cell(AW'(2));
		drain_results();
		program_console(8'hFF, 8'hFF, 8'h00);
		put_char(tcw_pkg::CH_TAB);
		put_char(tcw_pkg::CH_TAB);
		drain_results();
	endtask

	// Random beats under one setting of the registers and of idling
	task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct,
		input logic [7:0] tab, input logic [7:0] text, input logic [7:0] fill);
		int pick;
		int near;
		program_console(tab, text, fill);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				// half the reads look just behind the cursor
				near = shadow_row * COLS + shadow_col - $urandom_range(4);
				if ($urandom_range(1) && near >= 0)
					read_cell(AW'(near));
				else
					read_cell(AW'($urandom_range(2047)));
			end else if (pick < 20)
				put_char(tcw_pkg::CH_LF);
			else if (pick < 28)
				put_char(tcw_pkg::CH_BS);
			else if (pick < 36)
				put_char(tcw_pkg::CH_TAB);
			else if (pick < 39)
				put_char(tcw_pkg::CH_NUL);
			else
				put_char(8'($urandom_range(255)));
		end
		drain_results();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin : result_check
		console_beat_t want;
		console_beat_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.col  = cursor_column;
			got.row  = cursor_row;
			got.loc  = cursor_location;
			got.data = cell_data;
			got.scr  = scrolled;
			if (pending_beats.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_MAX)
					$display("unexpected beat: col %0d row %0d loc %0d data %h scrolled %0d",
						got.col, got.row, got.loc, got.data, got.scr);
			end else begin
				want = pending_beats.pop_front();
				if (want.col !== got.col || want.row !== got.row || want.loc !== got.loc ||
					want.data !== got.data || want.scr !== got.scr) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display("beat mismatch: exp col %0d row %0d loc %0d data %h scr %0d, %s",
							want.col, want.row, want.loc, want.data, want.scr,
							$sformatf("got col %0d row %0d loc %0d data %h scr %0d",
								got.col, got.row, got.loc, got.data, got.scr));
				end
			end
		end
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("text_console_writer_top_tb: done, errors");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mode       = MODE_PUT;
		char_code  = tcw_pkg::CH_NUL;
		read_index = '0;
		cfg_we     = 1'b0;
		cfg_index  = tcw_pkg::CFG_TAB_WIDTH;
		cfg_wdata  = '0;
		for (int k = 0; k < NCELLS; k++)
			shadow_cells[k] = tcw_pkg::RESET_CELL;
		shadow_col  = 0;
		shadow_row  = 0;
		shadow_tab  = tcw_pkg::TAB_WIDTH_RST;
		shadow_text = tcw_pkg::TEXT_ATTR_RST;
		shadow_fill = tcw_pkg::FILL_ATTR_RST;
		repeat (11)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_cursor_controls();
		test_tab_width_extremes();
		test_random_traffic(200, 0, 0, 8'd8, 8'h1E, 8'h07);
		test_random_traffic(250, 86, 0, 8'd1, 8'($urandom_range(255)), 8'($urandom_range(255)));
		test_random_traffic(250, 0, 86, 8'd80, 8'($urandom_range(255)), 8'($urandom_range(255)));
		test_random_traffic(250, 13, 13, 8'd81, 8'h00, 8'hFF);
		test_random_traffic(250, 0, 0, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));

		// late results would show up as unexpected beats here
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fault_count == 0)
			$display("text_console_writer_top_tb: done, clean");
		else
			$display("text_console_writer_top_tb: done, errors");
		$finish;
	end

endmodule
